FILE: src/rwht_pkg.sv
// Package for the random walk hitting time block.
// Holds field widths, fixed-point constants, register codes and the cell control struct.
// No dependencies.
package rwht_pkg;

  localparam int NODE_W    = 4;
  localparam int WEIGHT_W  = 16;
  localparam int SUM_W     = 21;
  localparam int PROB_W    = 32;
  localparam int RES_W     = 32;
  localparam int NCOUNT_W  = 5;
  localparam int STEP_W    = 14;
  localparam int CFG_W     = 14;
  localparam int CFG_IDX_W = 2;
  localparam int ACCUM_W   = 64;
  localparam int RES_SHIFT = 14;

  localparam logic [SUM_W-1:0]  SUM_MAX        = '1;
  localparam logic [PROB_W-1:0] ONE_Q32        = '1;
  localparam logic [STEP_W-1:0] STEP_LIMIT_RST = 14'd10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NODE_COUNT,
    REG_START_NODE,
    REG_TARGET_NODE,
    REG_STEP_LIMIT
  } cfg_reg_e;

  typedef struct packed {
    logic edge_we;
    logic prob_rd;
    logic prob_we;
    logic walk_init;
    logic vec_load;
    logic vec_issue;
    logic vec_mul;
    logic vec_acc;
    logic vec_commit;
    logic clear;
  } cell_ctl_t;

endpackage

FILE: src/rwht_if.sv
// Stream interfaces for edge beats in and result beats out.
// Depends on rwht_pkg for the payload widths.
interface rwht_edge_if;
  import rwht_pkg::*;
  logic                valid;
  logic                ready;
  logic [NODE_W-1:0]   node_a;
  logic [NODE_W-1:0]   node_b;
  logic [WEIGHT_W-1:0] edge_weight;
  logic                last_edge;
  modport source(output valid, node_a, node_b, edge_weight, last_edge, input ready);
  modport sink(input valid, node_a, node_b, edge_weight, last_edge, output ready);
endinterface

interface rwht_res_if;
  import rwht_pkg::*;
  logic             valid;
  logic             ready;
  logic [RES_W-1:0] expected_steps;
  modport source(output valid, expected_steps, input ready);
  modport sink(input valid, expected_steps, output ready);
endinterface

FILE: src/rwht_div.sv
// Restoring divider producing a saturated Q0.32 probability weight * 2^32 / sum.
// One quotient bit per cycle. Depends on rwht_pkg.
module rwht_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [rwht_pkg::WEIGHT_W-1:0] weight_i,
  input  logic [rwht_pkg::SUM_W-1:0]    sum_i,
  output logic                          done_o,
  output logic [rwht_pkg::PROB_W-1:0]   quot_o
);
  import rwht_pkg::*;

  localparam int QUO_W = PROB_W + 1;
  localparam int CNT_W = $clog2(QUO_W + 1);

  logic               busy_q;
  logic               done_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [SUM_W-1:0]   rem_q;
  logic [SUM_W-1:0]   dsr_q;
  logic [QUO_W-1:0]   quo_q;
  logic               lsb_q;
  logic [SUM_W:0]     trial;

  assign trial = {rem_q, (cnt_q == CNT_W'(QUO_W)) ? lsb_q : 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(QUO_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= SUM_W'(weight_i >> 1);
      lsb_q <= weight_i[0];
      dsr_q <= sum_i;
      quo_q <= '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_q <= SUM_W'(trial - {1'b0, dsr_q});
        quo_q <= {quo_q[QUO_W-2:0], 1'b1};
      end else begin
        rem_q <= trial[SUM_W-1:0];
        quo_q <= {quo_q[QUO_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q[QUO_W-1] ? ONE_Q32 : quo_q[PROB_W-1:0];

endmodule

FILE: src/rwht_cell.sv
// One node cell: weight and probability column, row sum, walk entry and its MAC.
// Walk entries rotate through the ring of cells one position per cycle while vec_issue is set. Depends on rwht_pkg.
module rwht_cell #(
  parameter  int MAX_NODES = 16,
  parameter  int ID        = 0,
  localparam int AW        = $clog2(MAX_NODES),
  localparam int CW        = $clog2(MAX_NODES + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rwht_pkg::cell_ctl_t           ctl_i,
  input  logic [CW-1:0]                 n_i,
  input  logic [AW-1:0]                 node_a_i,
  input  logic [AW-1:0]                 node_b_i,
  input  logic [rwht_pkg::WEIGHT_W-1:0] weight_i,
  input  logic [AW-1:0]                 start_i,
  input  logic [AW-1:0]                 target_i,
  input  logic [AW-1:0]                 row_i,
  input  logic [AW-1:0]                 col_i,
  input  logic [rwht_pkg::PROB_W-1:0]   prob_i,
  input  logic [rwht_pkg::PROB_W-1:0]   sh_nbr_i,
  output logic [rwht_pkg::PROB_W-1:0]   sh_o,
  output logic [rwht_pkg::WEIGHT_W-1:0] weight_o,
  output logic [rwht_pkg::SUM_W-1:0]    sum_o,
  output logic [rwht_pkg::PROB_W-1:0]   vnext_o
);
  import rwht_pkg::*;

  localparam int ACW = PROB_W + CW;
  localparam logic [AW-1:0] MY_ID = AW'(ID);

  logic [WEIGHT_W-1:0]  wmem [MAX_NODES];
  logic [PROB_W-1:0]    pmem [MAX_NODES];
  logic [MAX_NODES-1:0] wvld_q;
  logic                 wrdv_q;
  logic [WEIGHT_W-1:0]  wrd_q;
  logic [SUM_W-1:0]     sum_q;
  logic [SUM_W+1:0]     sum_add;
  logic [SUM_W-1:0]     sum_d;
  logic                 hit_a, hit_b, wen;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        k_q, k_last;
  logic [PROB_W-1:0]    v_q, sh_q, shd_q, prd_q;
  logic [2*PROB_W-1:0]  prod_q;
  logic [ACW-1:0]       acc_q;

  assign hit_a  = node_a_i == MY_ID;
  assign hit_b  = node_b_i == MY_ID;
  assign waddr  = hit_b ? node_a_i : node_b_i;
  assign wen    = ctl_i.edge_we && (hit_a || hit_b);
  assign k_last = AW'(n_i - 1'b1);

  assign sum_add = (SUM_W+2)'(sum_q) + (SUM_W+2)'(hit_a ? weight_i : '0)
                 + (SUM_W+2)'(hit_b ? weight_i : '0);
  assign sum_d   = (sum_add > (SUM_W+2)'(SUM_MAX)) ? SUM_MAX : sum_add[SUM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wvld_q <= '0;
      wrdv_q <= 1'b0;
      sum_q  <= '0;
    end else begin
      if (ctl_i.clear) begin
        wvld_q <= '0;
        sum_q  <= '0;
      end else if (wen) begin
        wvld_q[waddr] <= 1'b1;
        sum_q         <= sum_d;
      end
      if (ctl_i.prob_rd) begin
        wrdv_q <= wvld_q[row_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wen) begin
      wmem[waddr] <= weight_i;
    end
    if (ctl_i.prob_rd) begin
      wrd_q <= wmem[row_i];
    end
    if (ctl_i.prob_we && (col_i == MY_ID)) begin
      pmem[row_i] <= prob_i;
    end
    if (ctl_i.vec_issue) begin
      prd_q <= pmem[k_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.walk_init) begin
      v_q <= (start_i == MY_ID) ? ONE_Q32 : '0;
    end else if (ctl_i.vec_commit) begin
      v_q <= (target_i == MY_ID) ? '0 : vnext_o;
    end
    if (ctl_i.vec_load) begin
      sh_q  <= v_q;
      k_q   <= MY_ID;
      acc_q <= '0;
    end else if (ctl_i.vec_issue) begin
      shd_q <= sh_q;
      sh_q  <= sh_nbr_i;
      k_q   <= (k_q == k_last) ? '0 : k_q + 1'b1;
    end
    if (ctl_i.vec_mul) begin
      prod_q <= (2*PROB_W)'(shd_q) * (2*PROB_W)'(prd_q);
    end
    if (ctl_i.vec_acc) begin
      acc_q <= acc_q + ACW'(prod_q[2*PROB_W-1:PROB_W]);
    end
  end

  assign sh_o     = sh_q;
  assign weight_o = wrdv_q ? wrd_q : '0;
  assign sum_o    = sum_q;
  assign vnext_o  = (acc_q > ACW'(ONE_Q32)) ? ONE_Q32 : acc_q[PROB_W-1:0];

endmodule

FILE: src/random_walk_hitting_time.sv
// Random walk hitting time: a ring of node cells, a shared divider and a sequencer.
// An edge beat without last_edge is only stored. A last_edge beat starts building the n*n
// probabilities (shared serial divider), then runs step_limit-1 walk steps (each a
// rotation through the cell ring) before the result is issued.
// One item is in work at a time; a result waits in an output register.
// Reset clears configuration to defaults, all weights and row sums at once.
module random_walk_hitting_time #(
  parameter  int MAX_NODES = 16,
  localparam int AW        = $clog2(MAX_NODES),
  localparam int CW        = $clog2(MAX_NODES + 1),
  localparam int CNTW      = $clog2(MAX_NODES + 4)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rwht_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rwht_pkg::CFG_W-1:0]     cfg_wdata_i,
  rwht_edge_if.sink                      edge_i,
  rwht_res_if.source                     res_o
);
  import rwht_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PRD, S_PWT, S_PDIV, S_PWR, S_WINIT, S_STEP, S_DRAIN, S_OUT
  } state_e;

  localparam int PW = STEP_W + PROB_W;

  state_e               state_q;
  logic [NCOUNT_W-1:0]  nc_q;
  logic [NODE_W-1:0]    start_q, tgt_q;
  logic [STEP_W-1:0]    lim_q;
  logic [CW-1:0]        n_eff;
  logic                 start_ok, tgt_ok, edge_ok, accept, out_free;
  logic [AW-1:0]        i_q, j_q, last_idx;
  logic [CNTW-1:0]      cnt_q;
  logic [STEP_W-1:0]    step_q, ts_q;
  logic [PROB_W-1:0]    tv_q, pdat_q;
  logic                 mulv_q, accv_q, mv_q, av_q;
  logic [PW-1:0]        p_q;
  logic [ACCUM_W-1:0]   res_q;
  logic                 ovalid_q;
  logic [RES_W-1:0]     odata_q, res_sat;
  cell_ctl_t            ctl;
  logic                 div_start, div_done;
  logic [PROB_W-1:0]    div_quot;
  logic [WEIGHT_W-1:0]  w_sel;
  logic [SUM_W-1:0]     s_sel;

  logic [PROB_W-1:0]    sh_w    [MAX_NODES];
  logic [PROB_W-1:0]    nbr_w   [MAX_NODES];
  logic [PROB_W-1:0]    vnext_w [MAX_NODES];
  logic [WEIGHT_W-1:0]  wgt_w   [MAX_NODES];
  logic [SUM_W-1:0]     sum_w   [MAX_NODES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nc_q    <= NCOUNT_W'(1);
      start_q <= '0;
      tgt_q   <= '0;
      lim_q   <= STEP_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_NODE_COUNT:  nc_q    <= cfg_wdata_i[NCOUNT_W-1:0];
        REG_START_NODE:  start_q <= cfg_wdata_i[NODE_W-1:0];
        REG_TARGET_NODE: tgt_q   <= cfg_wdata_i[NODE_W-1:0];
        REG_STEP_LIMIT:  lim_q   <= cfg_wdata_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (nc_q == '0) begin
      n_eff = CW'(1);
    end else if (32'(nc_q) > MAX_NODES) begin
      n_eff = CW'(MAX_NODES);
    end else begin
      n_eff = CW'(nc_q);
    end
  end

  assign start_ok = 32'(start_q) < 32'(n_eff);
  assign tgt_ok   = 32'(tgt_q) < 32'(n_eff);
  assign edge_ok  = (edge_i.edge_weight != '0) && (32'(edge_i.node_a) < MAX_NODES)
                 && (32'(edge_i.node_b) < MAX_NODES);
  assign edge_i.ready = state_q == S_IDLE;
  assign accept   = edge_i.valid && edge_i.ready;
  assign out_free = !ovalid_q || res_o.ready;
  assign last_idx = AW'(n_eff - 1'b1);
  assign w_sel    = wgt_w[j_q];
  assign s_sel    = sum_w[i_q];
  assign res_sat  = (res_q[ACCUM_W-1:RES_SHIFT+RES_W] != '0) ? ONE_Q32
                  : res_q[RES_SHIFT+RES_W-1:RES_SHIFT];

  always_comb begin
    ctl            = '0;
    ctl.edge_we    = accept && edge_ok;
    ctl.prob_rd    = state_q == S_PRD;
    ctl.prob_we    = state_q == S_PWR;
    ctl.walk_init  = state_q == S_WINIT;
    ctl.vec_load   = (state_q == S_STEP) && (cnt_q == '0);
    ctl.vec_issue  = (state_q == S_STEP) && (cnt_q != '0) && (cnt_q <= CNTW'(n_eff));
    ctl.vec_mul    = mulv_q;
    ctl.vec_acc    = accv_q;
    ctl.vec_commit = (state_q == S_STEP) && (cnt_q == CNTW'(n_eff) + CNTW'(3));
    ctl.clear      = (state_q == S_OUT) && out_free;
  end

  assign div_start = (state_q == S_PWT) && (w_sel != '0) && (s_sel != '0);

  rwht_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .weight_i (w_sel),
    .sum_i    (s_sel),
    .done_o   (div_done),
    .quot_o   (div_quot)
  );

  for (genvar g = 0; g < MAX_NODES; g++) begin : g_cell
    assign nbr_w[g] = (CW'(g + 1) == n_eff) ? sh_w[0] : sh_w[(g + 1) % MAX_NODES];

    rwht_cell #(
      .MAX_NODES (MAX_NODES),
      .ID        (g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .n_i      (n_eff),
      .node_a_i (AW'(edge_i.node_a)),
      .node_b_i (AW'(edge_i.node_b)),
      .weight_i (edge_i.edge_weight),
      .start_i  (AW'(start_q)),
      .target_i (AW'(tgt_q)),
      .row_i    (i_q),
      .col_i    (j_q),
      .prob_i   (pdat_q),
      .sh_nbr_i (nbr_w[g]),
      .sh_o     (sh_w[g]),
      .weight_o (wgt_w[g]),
      .sum_o    (sum_w[g]),
      .vnext_o  (vnext_w[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      i_q      <= '0;
      j_q      <= '0;
      cnt_q    <= '0;
      step_q   <= '0;
      ts_q     <= '0;
      tv_q     <= '0;
      pdat_q   <= '0;
      mulv_q   <= 1'b0;
      accv_q   <= 1'b0;
      mv_q     <= 1'b0;
      av_q     <= 1'b0;
      p_q      <= '0;
      res_q    <= '0;
      ovalid_q <= 1'b0;
      odata_q  <= '0;
    end else begin
      mulv_q <= ctl.vec_issue;
      accv_q <= mulv_q;
      mv_q   <= ctl.vec_commit;
      av_q   <= mv_q;
      if (mv_q) begin
        p_q <= PW'(ts_q) * PW'(tv_q);
      end
      if (av_q) begin
        res_q <= res_q + ACCUM_W'(p_q);
      end
      if (res_o.valid && res_o.ready) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept && edge_i.last_edge) begin
            res_q <= '0;
            i_q   <= '0;
            j_q   <= '0;
            if (start_ok && tgt_ok && (lim_q >= STEP_W'(2))) begin
              state_q <= S_PRD;
            end else begin
              state_q <= S_DRAIN;
            end
          end
        end
        S_PRD: begin
          state_q <= S_PWT;
        end
        S_PWT: begin
          if (div_start) begin
            state_q <= S_PDIV;
          end else begin
            pdat_q  <= '0;
            state_q <= S_PWR;
          end
        end
        S_PDIV: begin
          if (div_done) begin
            pdat_q  <= div_quot;
            state_q <= S_PWR;
          end
        end
        S_PWR: begin
          if (j_q == last_idx) begin
            j_q <= '0;
            if (i_q == last_idx) begin
              state_q <= S_WINIT;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= S_PRD;
            end
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= S_PRD;
          end
        end
        S_WINIT: begin
          step_q  <= STEP_W'(1);
          cnt_q   <= '0;
          state_q <= S_STEP;
        end
        S_STEP: begin
          if (ctl.vec_commit) begin
            ts_q   <= step_q;
            tv_q   <= vnext_w[AW'(tgt_q)];
            step_q <= step_q + 1'b1;
            cnt_q  <= '0;
            if (step_q == lim_q - 1'b1) begin
              state_q <= S_DRAIN;
            end
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_DRAIN: begin
          if (!mv_q && !av_q) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            ovalid_q <= 1'b1;
            odata_q  <= res_sat;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_o.valid          = ovalid_q;
  assign res_o.expected_steps = odata_q;

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP) |-> (step_q < lim_q))
    else $error("walk step counter reached the step limit");

  a_target_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP) |-> (32'(tgt_q) < 32'(n_eff)))
    else $error("walk running with an inactive target node");

  a_accum_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |-> (!mv_q && !av_q))
    else $error("result issued before the accumulator settled");

endmodule

FILE: tb/random_walk_hitting_time_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for random_walk_hitting_time: edge beats in, hitting time beats out.
// Depends on rwht_pkg, the rwht_edge_if / rwht_res_if interfaces and the block itself.
module random_walk_hitting_time_tb;
  import rwht_pkg::*;

  localparam int NODES = 16;

  typedef struct packed {
    logic [4:0]          ncount;
    logic [3:0]          start;
    logic [3:0]          target;
    logic [13:0]         limit;
    logic [3:0]          a;
    logic [3:0]          b;
    logic [WEIGHT_W-1:0] w;
    logic                last;
    logic                chk;
    logic [RES_W-1:0]    exp_val;
  } edge_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  rwht_edge_if edge_if();
  rwht_res_if res_if();

  random_walk_hitting_time dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .edge_i(edge_if),
    .res_o(res_if)
  );

  logic [WEIGHT_W-1:0] weights[NODES][NODES];
  logic [SUM_W-1:0] sums[NODES];
  logic [4:0] m_ncount;
  logic [3:0] m_start;
  logic [3:0] m_target;
  logic [13:0] m_limit;

  logic [RES_W-1:0] pending_times[$];
  int errors = 0;
  bit quiet = 1'b0;
  int stall_left = 0;

  edge_row_t dir_rows[15] = '{
    '{5'd1, 4'd0, 4'd0, 14'd10000, 4'd15, 4'd15, 16'hFFFF, 1'b1, 1'b1, 32'd0},
    '{5'd2, 4'd0, 4'd1, 14'd40, 4'd0, 4'd1, 16'd1, 1'b0, 1'b0, 32'd0},
    '{5'd2, 4'd0, 4'd1, 14'd40, 4'd0, 4'd1, 16'd0, 1'b0, 1'b0, 32'd0},
    '{5'd2, 4'd0, 4'd1, 14'd40, 4'd0, 4'd1, 16'd3, 1'b1, 1'b0, 32'd0},
    '{5'd3, 4'd1, 4'd1, 14'd40, 4'd0, 4'd1, 16'hFFFF, 1'b0, 1'b0, 32'd0},
    '{5'd3, 4'd1, 4'd1, 14'd40, 4'd1, 4'd2, 16'h8000, 1'b0, 1'b0, 32'd0},
    '{5'd3, 4'd1, 4'd1, 14'd40, 4'd2, 4'd2, 16'd7, 1'b1, 1'b0, 32'd0},
    '{5'd0, 4'd0, 4'd0, 14'd40, 4'd0, 4'd0, 16'd5, 1'b1, 1'b0, 32'd0},
    '{5'd31, 4'd0, 4'd15, 14'd30, 4'd0, 4'd15, 16'd1, 1'b0, 1'b0, 32'd0},
    '{5'd31, 4'd0, 4'd15, 14'd30, 4'd15, 4'd0, 16'd2, 1'b1, 1'b0, 32'd0},
    '{5'd16, 4'd0, 4'd1, 14'd1, 4'd0, 4'd1, 16'd9, 1'b1, 1'b1, 32'd0},
    '{5'd16, 4'd0, 4'd1, 14'd0, 4'd0, 4'd1, 16'd9, 1'b1, 1'b1, 32'd0},
    '{5'd4, 4'd5, 4'd0, 14'd20, 4'd0, 4'd5, 16'd9, 1'b1, 1'b1, 32'd0},
    '{5'd4, 4'd0, 4'd9, 14'd20, 4'd0, 4'd1, 16'd9, 1'b1, 1'b1, 32'd0},
    '{5'd16, 4'd3, 4'd12, 14'd16383, 4'd3, 4'd7, 16'hFFFF, 1'b1, 1'b0, 32'd0}
  };

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] s, logic [WEIGHT_W-1:0] w);
    logic [SUM_W:0] t;
    t = s + w;
    return t > SUM_MAX ? SUM_MAX : t[SUM_W-1:0];
  endfunction

  function automatic logic [RES_W-1:0] hitting_time();
    int n;
    longint unsigned q;
    longint unsigned acc;
    longint unsigned total;
    logic [PROB_W-1:0] prob[NODES][NODES];
    logic [PROB_W-1:0] mass[NODES];
    logic [PROB_W-1:0] nxt[NODES];
    n = m_ncount;
    if (n < 1) n = 1;
    if (n > NODES) n = NODES;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        prob[i][j] = '0;
        if (sums[i] != 0) begin
          q = (longint'(weights[i][j]) << 32) / sums[i];
          prob[i][j] = q > ONE_Q32 ? ONE_Q32 : q[31:0];
        end
      end
    end
    if (m_start >= n || m_target >= n) return '0;
    for (int i = 0; i < NODES; i++) mass[i] = '0;
    mass[m_start] = ONE_Q32;
    total = 0;
    for (int s = 1; s < m_limit; s++) begin
      for (int j = 0; j < n; j++) begin
        acc = 0;
        for (int k = 0; k < n; k++) acc += (longint'(mass[k]) * prob[k][j]) >> 32;
        nxt[j] = acc > ONE_Q32 ? ONE_Q32 : acc[31:0];
      end
      for (int j = 0; j < n; j++) mass[j] = nxt[j];
      total += longint'(s) * mass[m_target];
      mass[m_target] = '0;
    end
    total = total >> RES_SHIFT;
    return total > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : total[31:0];
  endfunction

  function automatic void load_edge(edge_row_t r);
    if (r.w != 0) begin
      weights[r.a][r.b] = r.w;
      weights[r.b][r.a] = r.w;
      sums[r.a] = sat_add(sums[r.a], r.w);
      sums[r.b] = sat_add(sums[r.b], r.w);
    end
    if (r.last) begin
      pending_times.push_back(r.chk ? r.exp_val : hitting_time());
      for (int i = 0; i < NODES; i++) begin
        sums[i] = '0;
        for (int j = 0; j < NODES; j++) weights[i][j] = '0;
      end
    end
  endfunction

  task automatic write_regs(edge_row_t r);
    logic [CFG_W-1:0] vals[4];
    vals[0] = CFG_W'(r.ncount);
    vals[1] = CFG_W'(r.start);
    vals[2] = CFG_W'(r.target);
    vals[3] = CFG_W'(r.limit);
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= cfg_reg_e'(i);
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    m_ncount = r.ncount;
    m_start = r.start;
    m_target = r.target;
    m_limit = r.limit;
  endtask

  task automatic send_beat(edge_row_t r);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
    if (gap > 0) begin
      edge_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    edge_if.valid <= 1'b1;
    edge_if.node_a <= r.a;
    edge_if.node_b <= r.b;
    edge_if.edge_weight <= r.w;
    edge_if.last_edge <= r.last;
    @(posedge clk_i);
    while (!edge_if.ready) @(posedge clk_i);
    load_edge(r);
    if (r.last) begin
      edge_if.valid <= 1'b0;
      while (pending_times.size() != 0) @(posedge clk_i);
      repeat (8) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      res_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      res_if.ready <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_times.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: %h", res_if.expected_steps);
      end else begin
        if (res_if.expected_steps !== pending_times[0]) begin
          errors++;
          if (errors <= 10)
            $display("expected_steps mismatch: expected %h actual %h",
                     pending_times[0], res_if.expected_steps);
        end
        void'(pending_times.pop_front());
      end
    end
  end

  initial begin
    #50_000_000;
    $display("** random_walk_hitting_time: FAILED **");
    $finish;
  end

  initial begin
    edge_row_t r;
    int n_sets;
    int n_edges;
    int n;
    edge_if.valid = 1'b0;
    edge_if.node_a = '0;
    edge_if.node_b = '0;
    edge_if.edge_weight = '0;
    edge_if.last_edge = 1'b0;
    m_ncount = 5'd1;
    m_start = '0;
    m_target = '0;
    m_limit = STEP_LIMIT_RST;
    for (int i = 0; i < NODES; i++) begin
      sums[i] = '0;
      for (int j = 0; j < NODES; j++) weights[i][j] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 15; i++) begin
      if (i > 0 && dir_rows[i-1].last) write_regs(dir_rows[i]);
      send_beat(dir_rows[i]);
    end

    n_sets = 26;
    for (int s = 0; s < n_sets; s++) begin
      if (s >= n_sets - 6) quiet = 1'b1;
      case ($urandom_range(0, 9))
        0: r.ncount = 5'($urandom_range(0, 31));
        1: r.ncount = 5'd16;
        default: r.ncount = 5'($urandom_range(1, 6));
      endcase
      n = r.ncount == 0 ? 1 : (r.ncount > NODES ? NODES : r.ncount);
      r.start = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, n - 1));
      r.target = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, n - 1));
      r.limit = ($urandom_range(0, 14) == 0) ? 14'($urandom_range(0, 1))
                                             : 14'($urandom_range(2, 64));
      r.chk = 1'b0;
      r.exp_val = '0;
      write_regs(r);
      n_edges = (s == 4) ? 24 : $urandom_range(1, 5);
      for (int e = 0; e < n_edges; e++) begin
        if (s == 4) begin
          r.a = r.start;
          r.b = (e % 2 == 0) ? r.start : 4'($urandom_range(0, n - 1));
          r.w = 16'hFFFF;
        end else begin
          r.a = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(0, n - 1));
          r.b = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(0, n - 1));
          case ($urandom_range(0, 7))
            0: r.w = '0;
            1: r.w = 16'hFFFF;
            default: r.w = 16'($urandom);
          endcase
        end
        r.last = (e == n_edges - 1);
        send_beat(r);
      end
    end

    while (pending_times.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("** random_walk_hitting_time: PASSED **");
    end else begin
      $display("** random_walk_hitting_time: FAILED **");
    end
    $finish;
  end

endmodule
